// ===== rtl/core/windowed_rms_meter_core_macros.svh =====
// Assertion macros shared by the windowed RMS meter RTL.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef WINDOWED_RMS_METER_CORE_MACROS_SVH
`define WINDOWED_RMS_METER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WRM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/wrm_pkg.sv =====
// Shared types and constants of the windowed RMS meter.
// No dependencies.
package wrm_pkg;

   localparam int WINDOW_BITS = 16;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd4410;

   // CSR word index (byte address bit 2).
   localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

   // Input command codes.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Job queue between accumulator and divide/sqrt engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic empty;
      logic full;
      logic two_free;
   } q_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SQRT,
      BK_OUT
   } back_state_type;

endpackage

// ===== rtl/core/wrm_req_if.sv =====
// Sample/command channel of the windowed RMS meter.
// Valid/ready handshake; no package dependency.
interface wrm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);
endinterface

// ===== rtl/core/wrm_rsp_if.sv =====
// Result channel of the windowed RMS meter.
// Valid/ready handshake; no package dependency.
interface wrm_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] rms_level;
   logic                   partial_window;

   modport source (output valid, output rms_level, output partial_window, input ready);
   modport sink   (input valid, input rms_level, input partial_window, output ready);
endinterface

// ===== rtl/core/wrm_front.sv =====
// Front end: squares samples and accumulates them per window, queues finished windows.
// Depends on wrm_pkg and wrm_req_if.
module wrm_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16,
   parameter int SUM_BITS    = 2 * SAMPLE_BITS + COUNT_BITS - 2
) (
   input  logic                             clock,
   input  logic                             reset,
   wrm_req_if.sink                          req_ch,
   input  logic [wrm_pkg::WINDOW_BITS-1:0]  window_length,
   input  wrm_pkg::q_stat_type              q_stat,
   output logic                             push,
   output logic [SUM_BITS-1:0]              push_sum,
   output logic [COUNT_BITS-1:0]            push_count,
   output logic                             push_partial
);
   import wrm_pkg::*;

   localparam int SQ_BITS = 2 * SAMPLE_BITS - 1;
   localparam logic [31:0] COUNT_MAX32 = (32'd1 << COUNT_BITS) - 32'd1;

   // stage A: squared sample
   logic                   a_valid_ff, a_valid_in;
   logic                   a_flush_ff;
   logic [SQ_BITS-1:0]     a_square_ff;
   // stage B: window state
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic                   accept;
   logic [SAMPLE_BITS-1:0] mag;
   logic [2*SAMPLE_BITS-1:0] prod;
   logic [31:0]            win_wide;
   logic [COUNT_BITS-1:0]  win_eff;
   logic [SUM_BITS-1:0]    sum_add;
   logic [COUNT_BITS-1:0]  count_add;

   // a new item may emit one job; keep a slot for the one in stage A
   assign req_ch.ready = a_valid_ff ? q_stat.two_free : !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign a_valid_in   = accept;

   // magnitude as unsigned; full-scale negative maps to 2^(N-1)
   assign mag  = req_ch.sample[SAMPLE_BITS-1] ? (~req_ch.sample + 1'b1) : req_ch.sample;
   assign prod = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

   // zero window means one; clamp to what the counter holds
   always_comb begin
      win_wide = {{(32 - WINDOW_BITS){1'b0}}, window_length};
      if (win_wide == 32'd0) begin
         win_wide = 32'd1;
      end
      if (win_wide > COUNT_MAX32) begin
         win_wide = COUNT_MAX32;
      end
      win_eff = win_wide[COUNT_BITS-1:0];
   end

   assign sum_add   = sum_ff + {{(SUM_BITS - SQ_BITS){1'b0}}, a_square_ff};
   assign count_add = count_ff + {{(COUNT_BITS - 1){1'b0}}, 1'b1};

   always_comb begin
      push         = 1'b0;
      push_sum     = sum_add;
      push_count   = count_add;
      push_partial = 1'b0;
      sum_in       = sum_ff;
      count_in     = count_ff;
      if (a_valid_ff) begin
         if (a_flush_ff) begin
            push         = (count_ff != '0);
            push_sum     = sum_ff;
            push_count   = count_ff;
            push_partial = 1'b1;
         end else begin
            push     = (count_add >= win_eff);
            sum_in   = sum_add;
            count_in = count_add;
         end
         if (push) begin
            sum_in   = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_flush_ff  <= (req_ch.command == CMD_FLUSH);
         a_square_ff <= prod[SQ_BITS-1:0];
      end
   end

endmodule

// ===== rtl/core/wrm_fifo.sv =====
// Short job queue between the accumulator and the divide/sqrt engine.
// Depends on wrm_pkg and the assertion macro header.
`include "windowed_rms_meter_core_macros.svh"
module wrm_fifo #(
   parameter int WIDTH = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    push_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    pop_data,
   output wrm_pkg::q_stat_type stat
);
   import wrm_pkg::*;

   logic [WIDTH-1:0]          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LVL_BITS-1:0] level_ff, level_in;

   assign stat.empty    = (level_ff == '0);
   assign stat.full     = (level_ff == QUEUE_LVL_BITS'(QUEUE_DEPTH));
   assign stat.two_free = (level_ff <= QUEUE_LVL_BITS'(QUEUE_DEPTH - 2));
   assign pop_data      = slot_ff[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `WRM_ASSERT_SAME(a_no_overflow, push, !stat.full, "job pushed into full queue")
   `WRM_ASSERT_SAME(a_no_underflow, pop, !stat.empty, "job popped from empty queue")
   `WRM_ASSERT_NEXT(a_level_up, push && !pop, level_ff == $past(level_ff) + 1'b1, "queue level did not grow")

endmodule

// ===== rtl/core/wrm_back.sv =====
// Back end: restoring divide of sum by count, then digit-by-digit square root.
// Depends on wrm_pkg, wrm_rsp_if and the assertion macro header.
`include "windowed_rms_meter_core_macros.svh"
module wrm_back #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16,
   parameter int SUM_BITS    = 2 * SAMPLE_BITS + COUNT_BITS - 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wrm_pkg::q_stat_type   q_stat,
   input  logic [SUM_BITS-1:0]   job_sum,
   input  logic [COUNT_BITS-1:0] job_count,
   input  logic                  job_partial,
   output logic                  pop,
   wrm_rsp_if.source             rsp_ch
);
   import wrm_pkg::*;

   localparam int STEP_BITS = $clog2(SUM_BITS);
   localparam int MW = 2 * SAMPLE_BITS;
   localparam logic [SAMPLE_BITS-1:0] ROOT_MAX = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   back_state_type          state_ff, state_in;
   logic [STEP_BITS-1:0]    step_ff;
   logic [SUM_BITS-1:0]     work_ff, div_work_in;    // dividend/quotient, then radicand
   logic [COUNT_BITS-1:0]   div_ff;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]  root_ff, root_in;
   logic [SAMPLE_BITS:0]    sr_ff, sr_in;
   logic                    part_ff;

   logic [COUNT_BITS:0]     div_cat, div_diff;
   logic                    div_ge;
   logic [SAMPLE_BITS+2:0]  sq_cat, sq_trial, sq_diff;
   logic                    sq_ge;

   // one quotient bit per cycle
   assign div_cat     = {rem_ff, work_ff[SUM_BITS-1]};
   assign div_diff    = div_cat - {1'b0, div_ff};
   assign div_ge      = (div_cat >= {1'b0, div_ff});
   assign rem_in      = div_ge ? div_diff[COUNT_BITS-1:0] : div_cat[COUNT_BITS-1:0];
   assign div_work_in = {work_ff[SUM_BITS-2:0], div_ge};

   // one root bit per cycle from the top two radicand bits
   assign sq_cat   = {sr_ff, work_ff[MW-1:MW-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_diff  = sq_cat - sq_trial;
   assign sq_ge    = (sq_cat >= sq_trial);
   assign sr_in    = sq_ge ? sq_diff[SAMPLE_BITS:0] : sq_cat[SAMPLE_BITS:0];
   assign root_in  = {root_ff[SAMPLE_BITS-2:0], sq_ge};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == '0) begin
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            if (step_ff == '0) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (rsp_ch.ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      rsp_ch.valid = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop = !q_stat.empty;
         end
         BK_OUT: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
            pop          = 1'b0;
            rsp_ch.valid = 1'b0;
         end
      endcase
   end

   assign rsp_ch.rms_level      = root_ff;
   assign rsp_ch.partial_window = part_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               work_ff <= job_sum;
               div_ff  <= job_count;
               part_ff <= job_partial;
               rem_ff  <= '0;
               step_ff <= STEP_BITS'(SUM_BITS - 1);
            end
         end
         BK_DIV: begin
            work_ff <= div_work_in;
            rem_ff  <= rem_in;
            if (step_ff == '0) begin
               step_ff <= STEP_BITS'(SAMPLE_BITS - 1);
               root_ff <= '0;
               sr_ff   <= '0;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
         BK_SQRT: begin
            work_ff <= {work_ff[SUM_BITS-3:0], 2'b00};
            root_ff <= root_in;
            sr_ff   <= sr_in;
            step_ff <= step_ff - 1'b1;
         end
         default: begin
            part_ff <= part_ff;
         end
      endcase
   end

   `WRM_ASSERT_SAME(a_root_range, rsp_ch.valid, rsp_ch.rms_level <= ROOT_MAX, "root above full scale")
   `WRM_ASSERT_NEXT(a_div_done, state_ff == BK_DIV && step_ff == '0, state_ff == BK_SQRT,
      "divide did not hand over to sqrt")
   `WRM_ASSERT_SAME(a_mean_fits, state_ff == BK_SQRT && $past(state_ff) == BK_DIV,
      work_ff[SUM_BITS-1:MW-1] == '0, "mean wider than a full-scale square")

endmodule

// ===== rtl/core/windowed_rms_meter_core.sv =====
// Windowed RMS meter, top level: CSR block, accumulator front end, job queue, root engine.
// Depends on wrm_pkg, wrm_req_if, wrm_rsp_if, wrm_front, wrm_fifo and wrm_back.
//
// Usage:
//  - req_ch carries signed samples (command = sample) or an end-of-stream flush.
//    One transfer per cycle is taken while the job queue has room.
//  - After window_length samples a result transfer on rsp_ch gives
//    floor(sqrt(sum of squares / count)); a flush of a non-empty window gives the
//    same for the partial window with partial_window set; an empty flush gives nothing.
//  - From the closing sample to rsp_ch.valid the result passes the stage-A register,
//    the queue write and a queue pop, then the divider (one bit per cycle) and
//    the square-root unit (one bit per cycle).
//  - The root engine takes a new job only after its last result has left rsp_ch;
//    short windows then fill the 4-entry queue and req_ch.ready drops.
//  - A stalled rsp_ch holds the result; samples keep being accumulated until
//    the queue fills.
//  - Reset clears the window state and the queue and sets window_length to 4410.
//  - window_length lives at byte address 0 of the APB port; a zero length acts as one.
module windowed_rms_meter_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   wrm_req_if.sink     req_ch,
   wrm_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import wrm_pkg::*;

   localparam int SUM_BITS = 2 * SAMPLE_BITS + COUNT_BITS - 2;
   localparam int JOB_BITS = SUM_BITS + COUNT_BITS + 1;

   logic [WINDOW_BITS-1:0] window_ff;
   logic                   csr_wr;

   q_stat_type             q_stat;
   logic                   push, pop;
   logic [SUM_BITS-1:0]    push_sum, job_sum;
   logic [COUNT_BITS-1:0]  push_count, job_count;
   logic                   push_partial, job_partial;
   logic [JOB_BITS-1:0]    job_data;

   // CSR: zero-wait writes at the access phase
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2:2] == REG_WINDOW_LENGTH);
   assign prdata = (paddr[2:2] == REG_WINDOW_LENGTH) ?
                   {{(32 - WINDOW_BITS){1'b0}}, window_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_wr) begin
         window_ff <= pwdata[WINDOW_BITS-1:0];
      end
   end

   // squaring and window accumulation
   wrm_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .window_length (window_ff),
      .q_stat        (q_stat),
      .push          (push),
      .push_sum      (push_sum),
      .push_count    (push_count),
      .push_partial  (push_partial)
   );

   // finished windows wait here for the root engine
   wrm_fifo #(
      .WIDTH (JOB_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_partial, push_count, push_sum}),
      .pop       (pop),
      .pop_data  (job_data),
      .stat      (q_stat)
   );

   assign job_sum     = job_data[SUM_BITS-1:0];
   assign job_count   = job_data[SUM_BITS+COUNT_BITS-1:SUM_BITS];
   assign job_partial = job_data[JOB_BITS-1];

   // mean and square root, one result register toward rsp_ch
   wrm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_stat      (q_stat),
      .job_sum     (job_sum),
      .job_count   (job_count),
      .job_partial (job_partial),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule
